FILE: hw/rtl/itoa_pkg.sv
// Shared types, constants and helpers for the integer-to-ASCII formatter.
`default_nettype none

package itoa_pkg;

  localparam int unsigned DefaultValueBits = 64;
  localparam int unsigned OpWidth          = 3;
  localparam int unsigned InDataWidth      = 64;
  localparam int unsigned CharWidth        = 8;
  localparam int unsigned CountWidth       = 31;
  localparam int unsigned OutDataWidth     = 40;
  localparam int unsigned TextWidth        = 48;

  typedef enum logic [OpWidth-1:0] {
    OP_DEC   = 3'd0,
    OP_HEXL  = 3'd1,
    OP_HEXU  = 3'd2,
    OP_PTR   = 3'd3,
    OP_CHAR  = 3'd4,
    OP_NULL  = 3'd5
  } op_e;

  localparam logic [CharWidth-1:0] ChMinus = 8'h2d;
  localparam logic [CharWidth-1:0] ChZero  = 8'h30;
  localparam logic [CharWidth-1:0] ChX     = 8'h78;
  localparam logic [TextWidth-1:0] NullText = 48'h28_6e_75_6c_6c_29;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  function automatic logic [CharWidth-1:0] digit_char(input logic [3:0] nib,
                                                      input logic upper);
    logic [CharWidth-1:0] base;
    if (nib < 4'd10) begin
      base = ChZero;
    end else if (upper) begin
      base = 8'h37;
    end else begin
      base = 8'h57;
    end
    return base + {4'd0, nib};
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/integer_to_ascii_formatter.sv
// Top level: printf-style integer formatter emitting one ASCII character per transaction.
//
// Input stream: one transaction per formatting request. tuser carries the
// operation (signed decimal, lower hex, upper hex, pointer, character, null
// marker), tdata the 64-bit operand, of which the low VALUE_BITS bits are used.
// Output stream: one transaction per character, most significant first, with
// tlast on the final character of a request and the saturating running count.
// A request is taken only while the sequencer is idle. Decimal requests run a
// shift-and-add-3 converter over all VALUE_BITS bits, then drop leading zero digits
// one per cycle (up to NumDec-1), then emit one character per cycle while the
// receiver accepts. Hex and pointer skip up to NumHex-1 leading zeros, then emit.
// The minus sign and the 0x prefix are emitted as characters ahead of the digits;
// a character request emits its one byte and the null marker emits (null).
// The output register lets the next request be taken while the last character
// still waits; a stalled receiver holds the current character and stalls the
// sequencer before its next one. Reset empties the output and clears the count to zero.
`default_nettype none

module integer_to_ascii_formatter #(
  parameter int unsigned VALUE_BITS = itoa_pkg::DefaultValueBits
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid_i,
  output      logic                               s_axis_tready_o,
  input  wire logic [itoa_pkg::InDataWidth-1:0]   s_axis_tdata_i,  // [63:0] value
  input  wire logic [itoa_pkg::OpWidth-1:0]       s_axis_tuser_i,  // [2:0] operation
  output      logic                               m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  output      logic [itoa_pkg::OutDataWidth-1:0]  m_axis_tdata_o,  // [7:0] ascii_char,
                                                                   // [38:8] running_count
  output      logic                               m_axis_tlast_o
);
  import itoa_pkg::*;

  localparam int unsigned NumDec = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned NumHex = (VALUE_BITS + 3) / 4;
  localparam int unsigned DigW   = NumDec * 4;
  localparam int unsigned HexW   = NumHex * 4;
  localparam int unsigned PadW   = DigW - HexW;
  localparam int unsigned DcntW  = $clog2(NumDec + 1);
  localparam int unsigned ItW    = $clog2(VALUE_BITS);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SKIP = 5'b00100,
    ST_TXT  = 5'b01000,
    ST_DIG  = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic [VALUE_BITS-1:0]  bin_q, bin_d;
  logic [DigW-1:0]        dig_q, dig_d;
  logic [DcntW-1:0]       dcnt_q, dcnt_d;
  logic [ItW-1:0]         it_q, it_d;
  logic [TextWidth-1:0]   txt_q, txt_d;
  logic [2:0]             txt_n_q, txt_n_d;
  logic                   follow_q, follow_d;
  logic                   upper_q, upper_d;
  logic                   valid_q, valid_d;
  logic [CharWidth-1:0]   char_q, char_d;
  logic                   last_q, last_d;
  logic [CountWidth-1:0]  count_q, count_d;

  logic [VALUE_BITS-1:0]  val;
  logic [VALUE_BITS-1:0]  mag;
  logic [HexW-1:0]        hex_ext;
  logic [DigW-1:0]        bcd_adj;
  logic [3:0]             top_dig;
  logic                   out_free;
  logic                   load;

  assign val     = s_axis_tdata_i[VALUE_BITS-1:0];
  assign mag     = val[VALUE_BITS-1] ? (~val + VALUE_BITS'(1)) : val;
  assign hex_ext = HexW'(val);
  assign top_dig = dig_q[DigW-1 -: 4];
  assign out_free = !valid_q || m_axis_tready_i;

  always_comb begin
    for (int i = 0; i < NumDec; i++) begin
      if (dig_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = dig_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = dig_q[i*4 +: 4];
      end
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d  = state_q;
    bin_d    = bin_q;
    dig_d    = dig_q;
    dcnt_d   = dcnt_q;
    it_d     = it_q;
    txt_d    = txt_q;
    txt_n_d  = txt_n_q;
    follow_d = follow_q;
    upper_d  = upper_q;
    char_d   = char_q;
    last_d   = last_q;
    load     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          follow_d = 1'b1;
          upper_d  = 1'b0;
          txt_n_d  = 3'd0;
          dcnt_d   = DcntW'(NumHex);
          dig_d    = DigW'(hex_ext) << PadW;
          unique case (s_axis_tuser_i)
            OP_DEC: begin
              bin_d   = mag;
              dig_d   = '0;
              it_d    = ItW'(VALUE_BITS - 1);
              dcnt_d  = DcntW'(NumDec);
              txt_d   = {ChMinus, 40'd0};
              txt_n_d = val[VALUE_BITS-1] ? 3'd1 : 3'd0;
              state_d = ST_CONV;
            end
            OP_HEXL: begin
              state_d = ST_SKIP;
            end
            OP_HEXU: begin
              upper_d = 1'b1;
              state_d = ST_SKIP;
            end
            OP_PTR: begin
              txt_d   = {ChZero, ChX, 32'd0};
              txt_n_d = 3'd2;
              state_d = ST_SKIP;
            end
            OP_CHAR: begin
              txt_d    = {s_axis_tdata_i[7:0], 40'd0};
              txt_n_d  = 3'd1;
              follow_d = 1'b0;
              state_d  = ST_TXT;
            end
            OP_NULL: begin
              txt_d    = NullText;
              txt_n_d  = 3'd6;
              follow_d = 1'b0;
              state_d  = ST_TXT;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_CONV: begin
        dig_d = {bcd_adj[DigW-2:0], bin_q[VALUE_BITS-1]};
        bin_d = bin_q << 1;
        if (it_q == '0) begin
          state_d = ST_SKIP;
        end else begin
          it_d = it_q - ItW'(1);
        end
      end
      ST_SKIP: begin
        if (dcnt_q > DcntW'(1) && top_dig == 4'd0) begin
          dig_d  = dig_q << 4;
          dcnt_d = dcnt_q - DcntW'(1);
        end else if (txt_n_q != 3'd0) begin
          state_d = ST_TXT;
        end else begin
          state_d = ST_DIG;
        end
      end
      ST_TXT: begin
        if (out_free) begin
          load    = 1'b1;
          char_d  = txt_q[TextWidth-1 -: 8];
          last_d  = (txt_n_q == 3'd1) && !follow_q;
          txt_d   = txt_q << 8;
          txt_n_d = txt_n_q - 3'd1;
          if (txt_n_q == 3'd1) begin
            state_d = follow_q ? ST_DIG : ST_IDLE;
          end
        end
      end
      ST_DIG: begin
        if (out_free) begin
          load   = 1'b1;
          char_d = digit_char(top_dig, upper_q);
          last_d = (dcnt_q == DcntW'(1));
          dig_d  = dig_q << 4;
          dcnt_d = dcnt_q - DcntW'(1);
          if (dcnt_q == DcntW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q && !m_axis_tready_i;
    count_d = count_q;
    if (load) begin
      valid_d = 1'b1;
      if (count_q != CountMax) begin
        count_d = count_q + CountWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q    <= bin_d;
    dig_q    <= dig_d;
    dcnt_q   <= dcnt_d;
    it_q     <= it_d;
    txt_q    <= txt_d;
    txt_n_q  <= txt_n_d;
    follow_q <= follow_d;
    upper_q  <= upper_d;
    char_q   <= char_d;
    last_q   <= last_d;
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tdata_o  = {1'b0, count_q, char_q};

endmodule

`default_nettype wire
